// ----- hw/rtl/bsq_pkg.sv -----
// ----------------------------------------------------------------------------
// bsq_pkg
// shared types and constants of the component bitset query block
// ----------------------------------------------------------------------------
package bsq_pkg;

    localparam int NUM_ENTITIES    = 64;
    localparam int COMPONENT_COUNT = 32;

    localparam int ENT_W      = 6;
    localparam int COMP_W     = 5;
    localparam int CNT_W      = 7;
    localparam int MASK_W     = 64;
    localparam int COMP_DEPTH = 2 ** COMP_W;
    localparam int COMP_CHK_W = 9;

    // entities that can ever be members
    localparam logic [MASK_W-1:0] ENTITY_MASK =
        (NUM_ENTITIES >= MASK_W) ? {MASK_W{1'b1}}
                                 : ((MASK_W'(1) << NUM_ENTITIES) - MASK_W'(1));

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_TEST = 2'd1;
    localparam logic [1:0] CMD_TERM = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ENT_W-1:0]  entity;
        logic [COMP_W-1:0] component;
        logic              last_term;
    } in_item_t;

    typedef struct packed {
        logic              is_member;
        logic              found;
        logic [ENT_W-1:0]  matched_entity;
        logic [CNT_W-1:0]  match_count;
        logic              last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COUNT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic restart;
        logic step;
        logic count_en;
    } scan_cmd_t;

    typedef struct packed {
        logic             bit0;
        logic             rest_zero;
        logic             done;
        logic [ENT_W-1:0] index;
        logic [CNT_W-1:0] count;
    } scan_stat_t;

endpackage

// ----- hw/rtl/bsq_store.sv -----
// ----------------------------------------------------------------------------
// bsq_store
// membership mask memory, one row per component, registered read
// ----------------------------------------------------------------------------
module bsq_store (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               rd_en,
    input  logic [bsq_pkg::COMP_W-1:0]         rd_addr,
    output logic [bsq_pkg::MASK_W-1:0]         rd_data,
    input  logic                               wr_en,
    input  logic [bsq_pkg::COMP_W-1:0]         wr_addr,
    input  logic [bsq_pkg::MASK_W-1:0]         wr_data
);

    logic [bsq_pkg::MASK_W-1:0]     mem_reg [bsq_pkg::COMP_DEPTH];
    logic [bsq_pkg::COMP_DEPTH-1:0] vld_reg;
    logic [bsq_pkg::MASK_W-1:0]     rd_data_reg;
    logic                           rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    // rows never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ----- hw/rtl/bsq_scan.sv -----
// ----------------------------------------------------------------------------
// bsq_scan
// shift-right bit scanner: counts set bits, then walks them in ascending order
// ----------------------------------------------------------------------------
module bsq_scan (
    input  logic                         aclk,
    input  bsq_pkg::scan_cmd_t           cmd,
    input  logic [bsq_pkg::MASK_W-1:0]   load_vec,
    output bsq_pkg::scan_stat_t          stat
);

    logic [bsq_pkg::MASK_W-1:0] vec_reg, vec_next;
    logic [bsq_pkg::MASK_W-1:0] orig_reg, orig_next;
    logic [bsq_pkg::ENT_W-1:0]  idx_reg, idx_next;
    logic [bsq_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        vec_reg  <= vec_next;
        orig_reg <= orig_next;
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
    end

    always_comb begin
        vec_next  = vec_reg;
        orig_next = orig_reg;
        idx_next  = idx_reg;
        cnt_next  = cnt_reg;
        if (cmd.load) begin
            vec_next  = load_vec;
            orig_next = load_vec;
            idx_next  = '0;
            cnt_next  = '0;
        end else if (cmd.restart) begin
            vec_next = orig_reg;
            idx_next = '0;
        end else if (cmd.step) begin
            vec_next = {1'b0, vec_reg[bsq_pkg::MASK_W-1:1]};
            idx_next = idx_reg + 1'b1;
            if (cmd.count_en) begin
                cnt_next = cnt_reg + bsq_pkg::CNT_W'(vec_reg[0]);
            end
        end
    end

    assign stat.bit0      = vec_reg[0];
    assign stat.rest_zero = (vec_reg[bsq_pkg::MASK_W-1:1] == '0);
    assign stat.done      = (vec_reg == '0);
    assign stat.index     = idx_reg;
    assign stat.count     = cnt_reg;

endmodule

// ----- hw/rtl/component_bitset_query_core.sv -----
// ----------------------------------------------------------------------------
// component_bitset_query_core
// component membership store with bitset intersection query
// ----------------------------------------------------------------------------
// One item is taken at a time. Add, test and non-final query term items read
// memory when taken, then update or answer (a test waits for a free output
// register). A final query term runs a single bit scanner over the intersection
// twice, one bit per cycle unless the emit pass waits for the output register:
// a count pass that ends past the highest set bit and an emit pass ending on it;
// an empty match emits one marker item. Results sit in an output register, so
// the next item can be taken while the last result of the previous one still
// waits. The mask memory needs no clearing pass after reset.
module component_bitset_query_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bsq_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output bsq_pkg::out_item_t m_item
);

    bsq_pkg::state_t   state_reg, state_next;
    bsq_pkg::in_item_t item_reg, item_next;
    logic [bsq_pkg::MASK_W-1:0] acc_reg, acc_next;
    logic               out_valid_reg, out_valid_next;
    bsq_pkg::out_item_t out_item_reg, out_item_next;

    logic                          rd_en;
    logic [bsq_pkg::MASK_W-1:0]    rd_data;
    logic                          wr_en;
    logic [bsq_pkg::MASK_W-1:0]    wr_data;
    bsq_pkg::scan_cmd_t            scan_cmd;
    bsq_pkg::scan_stat_t           scan_stat;
    logic [bsq_pkg::MASK_W-1:0]    scan_load;

    logic                          accept;
    logic                          out_free;
    logic                          ent_ok;
    logic                          comp_ok;
    logic [bsq_pkg::MASK_W-1:0]    mask;
    logic [bsq_pkg::MASK_W-1:0]    term_acc;

    bsq_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (s_item.component),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (item_reg.component),
        .wr_data (wr_data)
    );

    bsq_scan u_scan (
        .aclk     (aclk),
        .cmd      (scan_cmd),
        .load_vec (scan_load),
        .stat     (scan_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bsq_pkg::ST_IDLE;
            acc_reg       <= '1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        out_item_reg <= out_item_next;
    end

    assign s_ready  = (state_reg == bsq_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign rd_en    = accept;
    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_item_reg;

    assign ent_ok  = ({1'b0, item_reg.entity} < bsq_pkg::CNT_W'(bsq_pkg::NUM_ENTITIES));
    assign comp_ok = ({{(bsq_pkg::COMP_CHK_W - bsq_pkg::COMP_W){1'b0}}, item_reg.component}
                      < bsq_pkg::COMP_CHK_W'(bsq_pkg::COMPONENT_COUNT));
    assign mask     = comp_ok ? rd_data : '0;
    assign term_acc = acc_reg & mask;
    assign wr_data  = mask | (bsq_pkg::MASK_W'(1) << item_reg.entity);
    assign scan_load = term_acc & bsq_pkg::ENTITY_MASK;

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        acc_next       = acc_reg;
        out_item_next  = out_item_reg;
        out_valid_next = m_ready ? 1'b0 : out_valid_reg;
        wr_en          = 1'b0;
        scan_cmd       = '0;

        unique case (state_reg)
            bsq_pkg::ST_IDLE: begin
                if (accept) begin
                    item_next  = s_item;
                    state_next = bsq_pkg::ST_EXEC;
                end
            end
            bsq_pkg::ST_EXEC: begin
                case (item_reg.cmd)
                    bsq_pkg::CMD_ADD: begin
                        wr_en      = ent_ok && comp_ok;
                        state_next = bsq_pkg::ST_IDLE;
                    end
                    bsq_pkg::CMD_TEST: begin
                        // read data holds while the output register is busy
                        if (out_free) begin
                            out_valid_next               = 1'b1;
                            out_item_next                = '0;
                            out_item_next.is_member      = ent_ok && mask[item_reg.entity];
                            out_item_next.last           = 1'b1;
                            state_next                   = bsq_pkg::ST_IDLE;
                        end
                    end
                    bsq_pkg::CMD_TERM: begin
                        if (item_reg.last_term) begin
                            scan_cmd.load = 1'b1;
                            acc_next      = '1;
                            state_next    = bsq_pkg::ST_COUNT;
                        end else begin
                            acc_next   = term_acc;
                            state_next = bsq_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        state_next = bsq_pkg::ST_IDLE;
                    end
                endcase
            end
            bsq_pkg::ST_COUNT: begin
                if (scan_stat.done) begin
                    scan_cmd.restart = 1'b1;
                    state_next       = bsq_pkg::ST_EMIT;
                end else begin
                    scan_cmd.step     = 1'b1;
                    scan_cmd.count_en = 1'b1;
                end
            end
            bsq_pkg::ST_EMIT: begin
                if (scan_stat.count == '0) begin
                    // empty match: one marker item
                    if (out_free) begin
                        out_valid_next     = 1'b1;
                        out_item_next      = '0;
                        out_item_next.last = 1'b1;
                        state_next         = bsq_pkg::ST_IDLE;
                    end
                end else if (!scan_stat.bit0) begin
                    scan_cmd.step = 1'b1;
                end else if (out_free) begin
                    scan_cmd.step                = 1'b1;
                    out_valid_next               = 1'b1;
                    out_item_next.is_member      = 1'b0;
                    out_item_next.found          = 1'b1;
                    out_item_next.matched_entity = scan_stat.index;
                    out_item_next.match_count    = scan_stat.count;
                    out_item_next.last           = scan_stat.rest_zero;
                    if (scan_stat.rest_zero) begin
                        state_next = bsq_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = bsq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// testbench of component_bitset_query_core: membership adds and tests, and
// multi-term intersection queries checked result by result against a local
// prediction of the mask store and the query accumulator, with random idle
// cycles on the command side and random stalls on the result side
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] CMD_NOP  = 2'd3;     // unused code, block must ignore it
    localparam int MAX_IDLE         = 14;
    localparam int DRAIN_CYCLES     = 400;      // longer than a full 64-bit scan
    localparam int RANDOM_ITEMS     = 113;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    bsq_pkg::in_item_t  s_item  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    bsq_pkg::out_item_t m_item;

    bsq_pkg::in_item_t           pending_cmds [$];
    bsq_pkg::out_item_t          expected_results [$];
    logic [bsq_pkg::MASK_W-1:0]  member_masks [bsq_pkg::COMP_DEPTH];
    logic [bsq_pkg::MASK_W-1:0]  term_accumulator;

    int error_count    = 0;
    int accepted_count = 0;
    int total_items    = 0;
    int send_wait      = 0;
    int send_calm      = 0;
    int recv_wait      = 0;
    int recv_calm      = 0;

    always #2 aclk = ~aclk;

    component_bitset_query_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // idle length for one item; now and then a calm stretch with no idling
    task automatic draw_idle(inout int calm_left, output int idle_cycles);
        if (calm_left > 0) begin
            calm_left--;
            idle_cycles = 0;
        end else if ($urandom_range(0, 11) == 0) begin
            calm_left   = $urandom_range(8, 24);
            idle_cycles = 0;
        end else begin
            idle_cycles = $urandom_range(0, MAX_IDLE);
        end
    endtask

    task automatic push_cmd(input logic [1:0] cmd, input logic [bsq_pkg::ENT_W-1:0] ent,
                            input logic [bsq_pkg::COMP_W-1:0] comp, input logic last_term);
        bsq_pkg::in_item_t c;
        c.cmd       = cmd;
        c.entity    = ent;
        c.component = comp;
        c.last_term = last_term;
        pending_cmds.push_back(c);
    endtask

    // mostly a few hot components so that intersections are not empty
    function automatic logic [bsq_pkg::COMP_W-1:0] pick_component();
        if ($urandom_range(0, 3) == 0)
            return bsq_pkg::COMP_W'($urandom_range(0, bsq_pkg::COMPONENT_COUNT - 1));
        return bsq_pkg::COMP_W'($urandom_range(0, 3));
    endfunction

    function automatic logic [bsq_pkg::ENT_W-1:0] rand_entity();
        return bsq_pkg::ENT_W'($urandom_range(0, 63));
    endfunction

    function automatic logic rand_flag();
        return 1'($urandom_range(0, 1));
    endfunction

    // update the predicted mask store and query accumulator for one item and queue the results it causes
    task automatic predict_bitset_results(input bsq_pkg::in_item_t it);
        logic [bsq_pkg::MASK_W-1:0] sel;
        logic [bsq_pkg::MASK_W-1:0] hits;
        bsq_pkg::out_item_t         r;
        int                         total;
        int                         top;
        sel   = (int'(it.component) < bsq_pkg::COMPONENT_COUNT) ?
                member_masks[it.component] : '0;
        r     = '0;
        total = 0;
        top   = 0;
        case (it.cmd)
            bsq_pkg::CMD_ADD: begin
                if (int'(it.entity) < bsq_pkg::NUM_ENTITIES &&
                    int'(it.component) < bsq_pkg::COMPONENT_COUNT)
                    member_masks[it.component][it.entity] = 1'b1;
            end
            bsq_pkg::CMD_TEST: begin
                r.is_member = (int'(it.entity) < bsq_pkg::NUM_ENTITIES) ?
                              sel[it.entity] : 1'b0;
                r.last      = 1'b1;
                expected_results.push_back(r);
            end
            bsq_pkg::CMD_TERM: begin
                term_accumulator &= sel;
                if (it.last_term) begin
                    hits             = term_accumulator & bsq_pkg::ENTITY_MASK;
                    term_accumulator = '1;
                    for (int i = 0; i < bsq_pkg::MASK_W; i++) begin
                        if (hits[i]) begin
                            total++;
                            top = i;
                        end
                    end
                    if (total == 0) begin
                        // empty match: single marker
                        r.last = 1'b1;
                        expected_results.push_back(r);
                    end else begin
                        for (int i = 0; i < bsq_pkg::MASK_W; i++) begin
                            if (hits[i]) begin
                                r.found          = 1'b1;
                                r.matched_entity = bsq_pkg::ENT_W'(i);
                                r.match_count    = bsq_pkg::CNT_W'(total);
                                r.last           = (i == top);
                                expected_results.push_back(r);
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_result(input bsq_pkg::out_item_t got);
        bsq_pkg::out_item_t want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
            return;
        end
        want = expected_results.pop_front();
        if (got.is_member !== want.is_member)
            report_mismatch($sformatf("is_member %b, want %b", got.is_member, want.is_member));
        if (got.found !== want.found)
            report_mismatch($sformatf("found %b, want %b", got.found, want.found));
        if (got.matched_entity !== want.matched_entity)
            report_mismatch($sformatf("matched_entity %0d, want %0d",
                                      got.matched_entity, want.matched_entity));
        if (got.match_count !== want.match_count)
            report_mismatch($sformatf("match_count %0d, want %0d",
                                      got.match_count, want.match_count));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %b, want %b (entity %0d)",
                                      got.last, want.last, want.matched_entity));
    endtask

    // command driver
    always @(posedge aclk) begin
        logic              next_valid;
        bsq_pkg::in_item_t next_item;
        next_valid = s_valid;
        next_item  = s_item;
        if (!aresetn) begin
            next_valid = 1'b0;
            for (int k = 0; k < bsq_pkg::COMP_DEPTH; k++)
                member_masks[k] = '0;
            term_accumulator = '1;
            draw_idle(send_calm, send_wait);
        end else begin
            if (s_valid && s_ready) begin
                predict_bitset_results(s_item);
                accepted_count++;
                next_valid = 1'b0;
                draw_idle(send_calm, send_wait);
            end
            if (!next_valid) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_cmds.size() > 0) begin
                    next_item  = pending_cmds.pop_front();
                    next_valid = 1'b1;
                end
            end
        end
        s_valid <= next_valid;
        s_item  <= next_item;
    end

    // result monitor with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            recv_wait = 0;
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_item);
                draw_idle(recv_calm, recv_wait);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int perm [bsq_pkg::MASK_W];
        int j;
        int tmp;
        int kind;
        int terms;
        int random_left;

        // fresh store: test miss and empty query
        push_cmd(bsq_pkg::CMD_TEST, 6'd0, 5'd0, 1'b0);
        push_cmd(bsq_pkg::CMD_TERM, 6'd0, 5'd0, 1'b1);
        // last_term set on add and test must not matter
        push_cmd(bsq_pkg::CMD_ADD, 6'd0, 5'd0, 1'b1);
        push_cmd(bsq_pkg::CMD_ADD, 6'd63, 5'd0, 1'b0);
        push_cmd(bsq_pkg::CMD_ADD, 6'd63, 5'd31, 1'b0);
        push_cmd(bsq_pkg::CMD_ADD, 6'd5, 5'd31, 1'b0);
        push_cmd(bsq_pkg::CMD_TEST, 6'd63, 5'd0, 1'b1);
        push_cmd(bsq_pkg::CMD_TEST, 6'd0, 5'd31, 1'b0);
        push_cmd(bsq_pkg::CMD_TEST, 6'd63, 5'd31, 1'b0);
        // entity field ignored by query terms
        push_cmd(bsq_pkg::CMD_TERM, 6'd63, 5'd0, 1'b1);
        push_cmd(bsq_pkg::CMD_TERM, 6'd0, 5'd31, 1'b0);
        push_cmd(bsq_pkg::CMD_TERM, 6'd17, 5'd0, 1'b1);
        push_cmd(CMD_NOP, 6'd0, 5'd0, 1'b1);
        push_cmd(bsq_pkg::CMD_TEST, 6'd0, 5'd0, 1'b0);
        // intersection with an empty mask, then accumulator must be all ones again
        push_cmd(bsq_pkg::CMD_TERM, 6'd0, 5'd31, 1'b0);
        push_cmd(bsq_pkg::CMD_TERM, 6'd0, 5'd1, 1'b0);
        push_cmd(bsq_pkg::CMD_TERM, 6'd0, 5'd31, 1'b1);
        push_cmd(bsq_pkg::CMD_TERM, 6'd0, 5'd31, 1'b1);
        push_cmd(bsq_pkg::CMD_ADD, 6'd63, 5'd31, 1'b0);
        push_cmd(bsq_pkg::CMD_ADD, 6'd42, 5'd21, 1'b0);
        push_cmd(bsq_pkg::CMD_TEST, 6'd42, 5'd21, 1'b0);
        push_cmd(bsq_pkg::CMD_TERM, 6'd21, 5'd21, 1'b1);

        // every entity into one component in shuffled order, then a full match
        for (int i = 0; i < bsq_pkg::MASK_W; i++)
            perm[i] = i;
        for (int i = bsq_pkg::MASK_W - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < bsq_pkg::MASK_W; i++)
            push_cmd(bsq_pkg::CMD_ADD, bsq_pkg::ENT_W'(perm[i]), 5'd30, rand_flag());
        push_cmd(bsq_pkg::CMD_TERM, rand_entity(), 5'd30, 1'b1);

        random_left = RANDOM_ITEMS;
        while (random_left > 0) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                push_cmd(bsq_pkg::CMD_ADD, rand_entity(), pick_component(), rand_flag());
                random_left--;
            end else if (kind < 58) begin
                push_cmd(bsq_pkg::CMD_TEST, rand_entity(), pick_component(), rand_flag());
                random_left--;
            end else if (kind < 90) begin
                terms = $urandom_range(1, 3);
                for (int t = 0; t < terms; t++)
                    push_cmd(bsq_pkg::CMD_TERM, rand_entity(),
                             ($urandom_range(0, 7) == 0) ? 5'd30 : pick_component(),
                             t == terms - 1);
                random_left -= terms;
            end else if (kind < 95) begin
                push_cmd(CMD_NOP, rand_entity(), bsq_pkg::COMP_W'($urandom_range(0, 31)),
                         rand_flag());
                random_left--;
            end else begin
                // term with no final one: narrows the next query
                push_cmd(bsq_pkg::CMD_TERM, rand_entity(), pick_component(), 1'b0);
                random_left--;
            end
        end
        total_items = pending_cmds.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_count < total_items)
            @(posedge aclk);
        while (expected_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        if (error_count == 0)
            $display("component_bitset_query_core regression: pass");
        else
            $display("component_bitset_query_core regression: fail");
        $finish;
    end

    // hang guard
    initial begin
        #5_000_000;
        $display("component_bitset_query_core regression: fail");
        $finish;
    end

endmodule
